// ===== sv/sh_l2_irradiance_eval_assert.svh =====
// Assertion macros for the SH L2 irradiance evaluator.
`ifndef SH_L2_IRRADIANCE_EVAL_ASSERT_SVH
`define SH_L2_IRRADIANCE_EVAL_ASSERT_SVH
`define SHL2_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SHL2_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== sv/shl2_pkg.sv =====
// Package: payload types, constants and helpers of the SH L2 evaluator.
`timescale 1ns / 1ps
package shl2_pkg;
  localparam int Slots = 9;
  localparam int Chans = 3;
  localparam logic [3:0] SlotLast = 4'd8;
  localparam logic [1:0] ChanLast = 2'd2;

  typedef enum logic {
    CmdWrite = 1'b0,
    CmdEval  = 1'b1
  } cmd_e;

  // constants K * 2^30 / 1e6, rounded
  localparam logic signed [31:0] KB0 = 32'sd302897200;
  localparam logic signed [31:0] KB1 = 32'sd524633476;
  localparam logic signed [31:0] KB4 = 32'sd1173114482;
  localparam logic signed [31:0] KB6 = 32'sd338649581;
  localparam logic signed [31:0] KB8 = 32'sd586557241;
  localparam logic signed [31:0] One30 = 32'sd1073741824;

  typedef struct packed {
    cmd_e               command;
    logic [3:0]         coeff_slot;
    logic [1:0]         coeff_channel;
    logic signed [31:0] coeff_value;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
  } in_item_t;

  typedef struct packed {
    logic [30:0] irradiance_red;
    logic [30:0] irradiance_green;
    logic [30:0] irradiance_blue;
  } out_item_t;

  // round half away from zero, drop 30 bits
  function automatic logic signed [33:0] rnd30(input logic signed [63:0] v);
    logic [63:0] m;
    logic [33:0] r;
    m = v[63] ? 64'(-v) : 64'(v);
    r = 34'((m + 64'd536870912) >> 30);
    return v[63] ? -$signed(r) : $signed(r);
  endfunction
endpackage

// ===== sv/sh_l2_irradiance_eval.sv =====
// Top level: SH L2 irradiance evaluator, coefficient table and pipeline.
// Takes one beat per cycle unless a stalled output holds the pipeline; an
// evaluate result shows on out_valid_o after its beat passes the squaring
// stage, the 16-stage square root, the 8-stage normalizing divider, the five
// basis/accumulate stages and the output register. The whole pipeline
// advances only when its last stage can move, so a stalled output holds every
// stage. Coefficient writes update the table at acceptance and give no
// result; they are taken only when the pipeline holds no evaluate.
`timescale 1ns / 1ps
`include "sh_l2_irradiance_eval_assert.svh"
module sh_l2_irradiance_eval import shl2_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);
  localparam int SqS = 16;
  localparam int DvS = 8;
  localparam int PreS = 1;
  localparam int VL = PreS + SqS + DvS;

  logic signed [31:0] tab_q [Slots*Chans];
  logic               adv;
  logic               acc;
  logic               evl;
  logic [VL-1:0]      v_q;
  logic               busy;

  // tail stages after the divider
  logic               t1_v_q, t2_v_q, t3_v_q, t4_v_q, t5_v_q, o_v_q;
  assign adv = !o_v_q || out_ready_i;
  assign busy = (|v_q) || t1_v_q || t2_v_q || t3_v_q || t4_v_q || t5_v_q || o_v_q;
  assign in_ready_o = adv && (in_data_i.command == CmdEval || !busy);
  assign acc = in_valid_i && in_ready_o;
  assign evl = acc && in_data_i.command == CmdEval;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Slots*Chans; i++) tab_q[i] <= '0;
    end else if (acc && in_data_i.command == CmdWrite && in_data_i.coeff_slot <= SlotLast
                 && in_data_i.coeff_channel <= ChanLast) begin
      tab_q[5'(in_data_i.coeff_slot) * 5'd3 + 5'(in_data_i.coeff_channel)]
        <= in_data_i.coeff_value;
    end
  end

  // stage 0: squares and length
  logic signed [15:0] x0_q, y0_q, z0_q;
  logic [32:0]        len2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      x0_q <= in_data_i.normal_x;
      y0_q <= in_data_i.normal_y;
      z0_q <= in_data_i.normal_z;
      len2_q <= 33'(32'(in_data_i.normal_x) * 32'(in_data_i.normal_x))
              + 33'(32'(in_data_i.normal_y) * 32'(in_data_i.normal_y))
              + 33'(32'(in_data_i.normal_z) * 32'(in_data_i.normal_z));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[VL-2:0], evl};
    end
  end

  logic [31:0] root;
  shl2_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  ({3'd0, len2_q, 28'd0}),
    .root_o (root)
  );

  // delay components and zero flag alongside the root
  logic signed [15:0] xd_q [SqS], yd_q [SqS], zd_q [SqS];
  logic               zr_q [SqS];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int s = 0; s < SqS; s++) begin
        xd_q[s] <= (s == 0) ? x0_q : xd_q[s-1];
        yd_q[s] <= (s == 0) ? y0_q : yd_q[s-1];
        zd_q[s] <= (s == 0) ? z0_q : zd_q[s-1];
        zr_q[s] <= (s == 0) ? (len2_q == '0) : zr_q[s-1];
      end
    end
  end

  logic [31:0] len_s;
  logic signed [15:0] xs, ys, zs;
  assign len_s = zr_q[SqS-1] ? 32'd1 : root;
  assign xs = xd_q[SqS-1];
  assign ys = yd_q[SqS-1];
  assign zs = zd_q[SqS-1];

  logic signed [31:0] ux, uy, uz;
  shl2_div u_dx (.clk_i(clk_i), .en_i(adv), .mag_i(xs[15] ? 16'(-xs) : 16'(xs)),
    .neg_i(xs[15]), .len_i(len_s), .unit_o(ux));
  shl2_div u_dy (.clk_i(clk_i), .en_i(adv), .mag_i(ys[15] ? 16'(-ys) : 16'(ys)),
    .neg_i(ys[15]), .len_i(len_s), .unit_o(uy));
  shl2_div u_dz (.clk_i(clk_i), .en_i(adv), .mag_i(zs[15] ? 16'(-zs) : 16'(zs)),
    .neg_i(zs[15]), .len_i(len_s), .unit_o(uz));

  logic zd2_q [DvS];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int s = 0; s < DvS; s++) zd2_q[s] <= (s == 0) ? zr_q[SqS-1] : zd2_q[s-1];
    end
  end

  // tail 1: unit vector products
  logic signed [31:0] ux1, uy1, uz1;
  assign ux1 = zd2_q[DvS-1] ? 32'sd0 : ux;
  assign uy1 = zd2_q[DvS-1] ? One30 : uy;
  assign uz1 = zd2_q[DvS-1] ? 32'sd0 : uz;

  logic signed [33:0] x2_q, y2_q, z2_q, xy_q, yz_q, xz_q;
  logic signed [31:0] ux_q, uy_q, uz_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      x2_q <= rnd30(64'(ux1) * 64'(ux1));
      y2_q <= rnd30(64'(uy1) * 64'(uy1));
      z2_q <= rnd30(64'(uz1) * 64'(uz1));
      xy_q <= rnd30(64'(ux1) * 64'(uy1));
      yz_q <= rnd30(64'(uy1) * 64'(uz1));
      xz_q <= rnd30(64'(ux1) * 64'(uz1));
      ux_q <= ux1;
      uy_q <= uy1;
      uz_q <= uz1;
    end
  end

  // tail 2: basis values
  logic signed [33:0] b_q [Slots];
  logic signed [35:0] t6, t8;
  assign t6 = 36'(z2_q) * 36'sd3 - 36'(One30);
  assign t8 = 36'(x2_q) - 36'(y2_q);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_q[0] <= 34'(KB0);
      b_q[1] <= rnd30(64'(KB1) * 64'(uy_q));
      b_q[2] <= rnd30(64'(KB1) * 64'(uz_q));
      b_q[3] <= rnd30(64'(KB1) * 64'(ux_q));
      b_q[4] <= rnd30(64'(64'(KB4) * 64'(xy_q)));
      b_q[5] <= rnd30(64'(64'(KB4) * 64'(yz_q)));
      b_q[6] <= rnd30(64'(64'(KB6) * 64'(t6)));
      b_q[7] <= rnd30(64'(64'(KB4) * 64'(xz_q)));
      b_q[8] <= rnd30(64'(64'(KB8) * 64'(t8)));
    end
  end

  // tail 3: weighted terms
  logic signed [33:0] p_q [Chans][Slots];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < Chans; c++)
        for (int k = 0; k < Slots; k++)
          p_q[c][k] <= rnd30(64'(tab_q[k*Chans+c]) * 64'(b_q[k]));
    end
  end

  // tail 4: partial sums
  logic signed [37:0] s_q [Chans][3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < Chans; c++)
        for (int g = 0; g < 3; g++)
          s_q[c][g] <= 38'(p_q[c][3*g]) + 38'(p_q[c][3*g+1]) + 38'(p_q[c][3*g+2]);
    end
  end

  // tail 5: final sum and clamp
  logic [30:0] r_q [Chans];
  always_ff @(posedge clk_i) begin
    logic signed [39:0] sm;
    if (adv) begin
      for (int c = 0; c < Chans; c++) begin
        sm = 40'(s_q[c][0]) + 40'(s_q[c][1]) + 40'(s_q[c][2]);
        if (sm < 0) r_q[c] <= '0;
        else if (sm > 40'sh007FFFFFFF) r_q[c] <= '1;
        else r_q[c] <= sm[30:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_v_q <= 1'b0;
      t2_v_q <= 1'b0;
      t3_v_q <= 1'b0;
      t4_v_q <= 1'b0;
      t5_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else if (adv) begin
      t1_v_q <= v_q[VL-1];
      t2_v_q <= t1_v_q;
      t3_v_q <= t2_v_q;
      t4_v_q <= t3_v_q;
      t5_v_q <= t4_v_q;
      o_v_q <= t5_v_q;
    end
  end

  out_item_t o_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_q.irradiance_red <= r_q[0];
      o_q.irradiance_green <= r_q[1];
      o_q.irradiance_blue <= r_q[2];
    end
  end

  assign out_valid_o = o_v_q;
  assign out_data_o = o_q;

  `SHL2_ASSERT_IMPL(a_write_idle, clk_i, rst_ni,
    acc && in_data_i.command == CmdWrite, !busy)
  `SHL2_ASSERT_NEXT(a_hold_stall, clk_i, rst_ni, o_v_q && !out_ready_i,
    o_v_q && $stable(o_q) && $stable(v_q))
  `SHL2_ASSERT_NEXT(a_eval_moves, clk_i, rst_ni, evl, v_q[0])
endmodule

// ===== sv/shl2_sqrt.sv =====
// Pipelined integer square root, two result bits per stage, 64-bit radicand.
`timescale 1ns / 1ps
module shl2_sqrt import shl2_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] rad_i,
  output logic [31:0] root_o
);
  localparam int Stg = 16;
  logic [63:0] rem_q [Stg];
  logic [31:0] res_q [Stg];
  logic [63:0] rem_d [Stg];
  logic [31:0] res_d [Stg];

  always_comb begin
    logic [63:0] rm;
    logic [31:0] rs;
    logic [65:0] t;
    for (int s = 0; s < Stg; s++) begin
      rm = (s == 0) ? rad_i : rem_q[s-1];
      rs = (s == 0) ? 32'd0 : res_q[s-1];
      for (int b = 0; b < 2; b++) begin
        t = {rs, 2'b01} << (62 - 4*s - 2*b);
        if ({2'b00, rm} >= t) begin
          rm = rm - t[63:0];
          rs = {rs[30:0], 1'b1};
        end else begin
          rs = {rs[30:0], 1'b0};
        end
      end
      rem_d[s] = rm;
      res_d[s] = rs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < Stg; s++) begin
        rem_q[s] <= rem_d[s];
        res_q[s] <= res_d[s];
      end
    end
  end
  assign root_o = res_q[Stg-1];
endmodule

// ===== sv/shl2_div.sv =====
// Pipelined restoring divider: round(mag * 2^44 / len) clipped to 2^30.
`timescale 1ns / 1ps
module shl2_div import shl2_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [15:0] mag_i,
  input  logic        neg_i,
  input  logic [31:0] len_i,
  output logic signed [31:0] unit_o
);
  // numerator up to 2^60+2^31 < 2^61; quotient below 2^31 plus guard
  localparam int QB = 32;
  localparam int Stg = 8;
  localparam int BPS = QB / Stg;
  logic [60:0] num_q [Stg];
  logic [32:0] rem_q [Stg];
  logic [QB-1:0] quo_q [Stg];
  logic [31:0] len_q [Stg];
  logic neg_q [Stg];
  logic [60:0] num_d [Stg];
  logic [32:0] rem_d [Stg];
  logic [QB-1:0] quo_d [Stg];

  // quotient bits above QB are zero since mag*2^44 < 2^31 * len
  always_comb begin
    logic [60:0] n;
    logic [32:0] r;
    logic [QB-1:0] qq;
    logic [31:0] l;
    logic [33:0] t;
    for (int s = 0; s < Stg; s++) begin
      if (s == 0) begin
        n = ({mag_i, 44'd0} | 61'd0) + 61'(len_i >> 1);
        r = 33'(n >> QB);
        qq = '0;
        l = len_i;
      end else begin
        n = num_q[s-1];
        r = rem_q[s-1];
        qq = quo_q[s-1];
        l = len_q[s-1];
      end
      for (int b = 0; b < BPS; b++) begin
        t = {r, n[QB-1-(s*BPS+b)]};
        if (t >= {2'b00, l}) begin
          t = t - {2'b00, l};
          qq = {qq[QB-2:0], 1'b1};
        end else begin
          qq = {qq[QB-2:0], 1'b0};
        end
        r = t[32:0];
      end
      num_d[s] = n;
      rem_d[s] = r;
      quo_d[s] = qq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < Stg; s++) begin
        num_q[s] <= num_d[s];
        rem_q[s] <= rem_d[s];
        quo_q[s] <= quo_d[s];
        len_q[s] <= (s == 0) ? len_i : len_q[s-1];
        neg_q[s] <= (s == 0) ? neg_i : neg_q[s-1];
      end
    end
  end

  logic [31:0] clip;
  assign clip = (quo_q[Stg-1] > 32'(One30)) ? 32'(One30) : quo_q[Stg-1];
  assign unit_o = neg_q[Stg-1] ? -$signed(clip) : $signed(clip);
endmodule

// ===== tb/sv/tb_sh_l2_irradiance_eval.sv =====
// Testbench for the SH L2 irradiance evaluator: random beats checked against a local model.
`timescale 1ns / 1ps
module tb_sh_l2_irradiance_eval import shl2_pkg::*;;

  class irradiance_scoreboard;
    logic signed [31:0] coeffs[27];
    out_item_t pending[$];
    int errors;
    int evals;
    int writes;

    function new();
      foreach (coeffs[i]) coeffs[i] = '0;
      errors = 0;
      evals = 0;
      writes = 0;
    endfunction

    static function longint round30(longint v);
      longint m;
      m = v < 0 ? -v : v;
      m = (m + (64'sd1 <<< 29)) >>> 30;
      return v < 0 ? -m : m;
    endfunction

    static function longint isqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return longint'(r);
    endfunction

    static function longint unit_of(longint c, longint unsigned len);
      longint unsigned mag;
      longint unsigned q;
      mag = c < 0 ? -c : c;
      q = ((mag << 44) + (len >> 1)) / len;
      if (q > (64'd1 << 30)) q = 64'd1 << 30;
      return c < 0 ? -longint'(q) : longint'(q);
    endfunction

    function void note_beat(in_item_t it);
      longint x, y, z, ux, uy, uz, x2, y2, z2, s, one;
      longint basis[9];
      longint unsigned len2, len;
      out_item_t r;
      logic [30:0] chv[3];
      if (it.command == CmdWrite) begin
        writes++;
        if (it.coeff_slot <= SlotLast && it.coeff_channel <= ChanLast)
          coeffs[it.coeff_slot * 3 + it.coeff_channel] = it.coeff_value;
        return;
      end
      evals++;
      one = 64'sd1 <<< 30;
      x = it.normal_x;
      y = it.normal_y;
      z = it.normal_z;
      len2 = x * x + y * y + z * z;
      if (len2 == 0) begin
        ux = 0;
        uy = one;
        uz = 0;
      end else begin
        len = isqrt(len2 << 28);
        ux = unit_of(x, len);
        uy = unit_of(y, len);
        uz = unit_of(z, len);
      end
      x2 = round30(ux * ux);
      y2 = round30(uy * uy);
      z2 = round30(uz * uz);
      basis[0] = KB0;
      basis[1] = round30(longint'(KB1) * uy);
      basis[2] = round30(longint'(KB1) * uz);
      basis[3] = round30(longint'(KB1) * ux);
      basis[4] = round30(longint'(KB4) * round30(ux * uy));
      basis[5] = round30(longint'(KB4) * round30(uy * uz));
      basis[6] = round30(longint'(KB6) * (3 * z2 - one));
      basis[7] = round30(longint'(KB4) * round30(ux * uz));
      basis[8] = round30(longint'(KB8) * (x2 - y2));
      for (int c = 0; c < 3; c++) begin
        s = 0;
        for (int k = 0; k < 9; k++) s += round30(longint'(coeffs[k * 3 + c]) * basis[k]);
        if (s < 0) s = 0;
        if (s > 64'sh7FFFFFFF) s = 64'sh7FFFFFFF;
        chv[c] = s[30:0];
      end
      r.irradiance_red = chv[0];
      r.irradiance_green = chv[1];
      r.irradiance_blue = chv[2];
      pending.push_back(r);
    endfunction

    function void check_beat(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("unexpected result beat %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.irradiance_red !== e.irradiance_red) begin
        $error("irradiance_red exp %0d got %0d", e.irradiance_red, got.irradiance_red);
        errors++;
      end
      if (got.irradiance_green !== e.irradiance_green) begin
        $error("irradiance_green exp %0d got %0d", e.irradiance_green, got.irradiance_green);
        errors++;
      end
      if (got.irradiance_blue !== e.irradiance_blue) begin
        $error("irradiance_blue exp %0d got %0d", e.irradiance_blue, got.irradiance_blue);
        errors++;
      end
    endfunction
  endclass

  localparam int Latency = 30;
  localparam longint CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_data_o;

  irradiance_scoreboard sb = new();
  longint cycles = 0;
  bit hold_off = 1'b0;
  int stall_cycles = 0;

  sh_l2_irradiance_eval uut (.*);

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout at cycle %0d", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_beat(in_data_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_beat(out_data_o);
  end

  // receiver: random stalls, plus one long hold-off when requested
  initial begin
    int wait_n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
      end else if (stall_cycles > 0) begin
        out_ready_i <= 1'b0;
        stall_cycles--;
      end else begin
        out_ready_i <= 1'b1;
        wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 1) == 0) stall_cycles = wait_n;
      end
    end
  end

  task automatic send(in_item_t it, int gap);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic put_coeff(int slot, int chan, logic signed [31:0] v, int gap);
    in_item_t it;
    it = '0;
    it.command = CmdWrite;
    it.coeff_slot = 4'(slot);
    it.coeff_channel = 2'(chan);
    it.coeff_value = v;
    it.normal_x = 16'($urandom);
    it.normal_y = 16'($urandom);
    it.normal_z = 16'($urandom);
    send(it, gap);
  endtask

  task automatic eval_normal(logic signed [15:0] x, y, z, int gap);
    in_item_t it;
    it.command = CmdEval;
    it.coeff_slot = 4'($urandom);
    it.coeff_channel = 2'($urandom);
    it.coeff_value = $urandom;
    it.normal_x = x;
    it.normal_y = y;
    it.normal_z = z;
    send(it, gap);
  endtask

  function automatic logic signed [31:0] rand_coeff();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
      2: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return $signed($urandom_range(0, 32'h3FFFFF)) - 32'sh100000;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return $signed(16'($urandom_range(0, 32))) - 16'sd16;
      2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
    endcase
  endfunction

  function automatic int rand_gap();
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
  endfunction

  task automatic drain();
    int n;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    n = 0;
    while (n < Latency + 8) begin
      @(posedge clk_i);
      n++;
    end
  endtask

  task automatic load_table(int mode);
    for (int s = 0; s < Slots; s++)
      for (int c = 0; c < Chans; c++)
        case (mode)
          0: put_coeff(s, c, 32'sh7FFFFFFF, 0);
          1: put_coeff(s, c, 32'sh80000000, 0);
          default: put_coeff(s, c, rand_coeff(), rand_gap());
        endcase
  endtask

  initial begin
    int issued;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // cleared table gives zero
    eval_normal(16'sd0, 16'sd16384, 16'sd0, 0);
    drain();
    // directed: small positive dc term, zero normal, axes and extremes
    put_coeff(0, 0, 32'sh00010000, 0);
    put_coeff(1, 1, 32'sh00020000, 0);
    put_coeff(8, 2, -32'sh00030000, 0);
    put_coeff(9, 0, 32'sh7FFFFFFF, 0);
    put_coeff(15, 1, 32'sh7FFFFFFF, 0);
    put_coeff(2, 3, 32'sh7FFFFFFF, 0);
    eval_normal(16'sd0, 16'sd0, 16'sd0, 0);
    eval_normal(16'sh7FFF, 16'sd0, 16'sd0, 0);
    eval_normal(16'sh8000, 16'sd0, 16'sd0, 0);
    eval_normal(16'sd0, 16'sh8000, 16'sd0, 0);
    eval_normal(16'sd0, 16'sd0, 16'sh7FFF, 0);
    eval_normal(16'sh8000, 16'sh8000, 16'sh8000, 0);
    eval_normal(16'sd1, 16'sd0, 16'sd0, 0);
    eval_normal(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0);
    drain();
    load_table(0);
    eval_normal(16'sd0, 16'sd16384, 16'sd0, 0);
    eval_normal(16'sd1, 16'sd1, 16'sd1, 0);
    drain();
    load_table(1);
    eval_normal(16'sd0, 16'sd16384, 16'sd0, 0);
    drain();

    // long receiver hold-off while the sender keeps going
    fork
      begin
        hold_off = 1'b1;
        repeat (150) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 80; i++) eval_normal(rand_comp(), rand_comp(), rand_comp(), 0);
    join
    drain();

    // random phases: reload table, then a stream of normals
    issued = 0;
    while (issued < 1700) begin
      load_table(2);
      issued += 27;
      for (int i = 0; i < 150; i++) begin
        eval_normal(rand_comp(), rand_comp(), rand_comp(),
                    ($urandom_range(0, 3) == 0) ? 0 : rand_gap());
        issued++;
      end
      drain();
    end

    $display("covered %0d coefficient writes and %0d evaluations", sb.writes, sb.evals);
    $display("directed extremes, zero normal, ignored writes and a long output stall");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ===== sh_l2_irradiance_eval.f =====
+incdir+sv
sv/shl2_pkg.sv
sv/shl2_sqrt.sv
sv/shl2_div.sv
sv/sh_l2_irradiance_eval.sv
tb/sv/tb_sh_l2_irradiance_eval.sv
